@@ design/rcc_pkg.sv @@
// Shared types and constants for the rod cutting block with result cache.
`timescale 1ns / 1ps
package rcc_pkg;

   localparam logic [23:0] VALUE_MAX = 24'hFFFFFF;
   localparam logic [15:0] LFSR_SEED = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REPLACE_POLICY = 2'd0,
      CSR_PIECE_COUNT    = 2'd1,
      CSR_CACHE_CAPACITY = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic {
      POLICY_LRU    = 1'b0,
      POLICY_RANDOM = 1'b1
   } policy_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  piece_index;
      logic [7:0]  piece_length;
      logic [15:0] piece_value;
      logic [7:0]  rod_length;
   } req_type;

   typedef struct packed {
      logic [23:0] best_value;
      logic        cache_hit;
   } rsp_type;

   // Status returned by the cache to the controller.
   typedef struct packed {
      logic        hit;
      logic        busy;
      logic        overfull;
      logic [23:0] answer;
   } cache_status_type;

endpackage

@@ design/rcc_dp_engine.sv @@
// Rod cutting recurrence over a piece table memory and a best-value memory.
`timescale 1ns / 1ps
module rcc_dp_engine #(
   parameter int MAX_PIECES = 16,
   parameter int MAX_ROD    = 255
) (
   input  logic clock,
   input  logic reset,
   input  logic load_en,
   input  logic [3:0] load_index,
   input  logic [7:0] load_length,
   input  logic [15:0] load_value,
   input  logic start,
   input  logic [$clog2(MAX_ROD+1)-1:0] rod_len,
   input  logic [$clog2(MAX_PIECES+1)-1:0] count,
   output logic done,
   output logic [23:0] result,
   output logic busy
);
   localparam int RW = $clog2(MAX_ROD + 1);
   localparam int PW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
   localparam int CW = $clog2(MAX_PIECES + 1);

   typedef enum logic [1:0] {E_IDLE, E_RUN, E_DRAIN, E_WRITE} state_type;

   state_type state_ff;
   logic [RW-1:0] len_ff, i_ff;
   logic [CW-1:0] j_ff, cnt_ff;
   logic [23:0] max_ff;
   logic s1_v_ff, s2_v_ff, s2_ok_ff;
   logic [7:0] pl_rd_ff;
   logic [15:0] pv_rd_ff, s2_val_ff;
   logic [23:0] best_rd_ff;
   logic done_ff;
   logic [23:0] result_ff;

   logic [7:0]  plen_mem [MAX_PIECES];
   logic [15:0] pval_mem [MAX_PIECES];
   logic [23:0] best_mem [MAX_ROD+1];

   logic issue;
   logic [PW-1:0] p_addr;
   logic s1_ok;
   logic [RW-1:0] b_addr;
   logic [24:0] cand_wide;
   logic [23:0] cand;
   logic b_we;
   logic [RW-1:0] b_wa;
   logic [23:0] b_wd;

   assign issue  = (state_ff == E_RUN) && (cnt_ff != '0);
   assign p_addr = PW'(j_ff);
   assign s1_ok  = (pl_rd_ff != 8'd0) && (32'(pl_rd_ff) <= 32'(i_ff));
   assign b_addr = RW'(32'(i_ff) - 32'(pl_rd_ff));
   assign cand_wide = {1'b0, best_rd_ff} + 25'(s2_val_ff);
   assign cand = cand_wide[24] ? rcc_pkg::VALUE_MAX : cand_wide[23:0];

   always_comb begin
      b_we = 1'b0;
      b_wa = '0;
      b_wd = '0;
      if (state_ff == E_IDLE && start) begin
         b_we = 1'b1;
      end else if (state_ff == E_WRITE) begin
         b_we = 1'b1;
         b_wa = i_ff;
         b_wd = max_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en && (32'(load_index) < MAX_PIECES)) begin
         plen_mem[PW'(load_index)] <= load_length;
         pval_mem[PW'(load_index)] <= load_value;
      end
      if (issue) begin
         pl_rd_ff <= plen_mem[p_addr];
         pv_rd_ff <= pval_mem[p_addr];
      end
      if (b_we) begin
         best_mem[b_wa] <= b_wd;
      end
      if (s1_v_ff) begin
         best_rd_ff <= best_mem[b_addr];
         s2_ok_ff   <= s1_ok;
         s2_val_ff  <= pv_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
         if (s2_v_ff && s2_ok_ff && (cand > max_ff)) begin
            max_ff <= cand;
         end
         case (state_ff)
            E_IDLE: begin
               if (start) begin
                  len_ff <= rod_len;
                  cnt_ff <= count;
                  i_ff   <= RW'(1);
                  j_ff   <= '0;
                  max_ff <= '0;
                  if (rod_len == '0) begin
                     done_ff   <= 1'b1;
                     result_ff <= '0;
                  end else begin
                     state_ff <= E_RUN;
                  end
               end
            end
            E_RUN: begin
               j_ff <= j_ff + CW'(1);
               if (cnt_ff == '0 || j_ff == cnt_ff - CW'(1)) begin
                  state_ff <= E_DRAIN;
               end
            end
            E_DRAIN: begin
               if (!s1_v_ff && !s2_v_ff) begin
                  state_ff <= E_WRITE;
               end
            end
            E_WRITE: begin
               if (i_ff == len_ff) begin
                  done_ff   <= 1'b1;
                  result_ff <= max_ff;
                  state_ff  <= E_IDLE;
               end else begin
                  i_ff     <= i_ff + RW'(1);
                  j_ff     <= '0;
                  max_ff   <= '0;
                  state_ff <= E_RUN;
               end
            end
            default: state_ff <= E_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
   assign busy   = (state_ff != E_IDLE);

endmodule

@@ design/rcc_cache.sv @@
// Small fully associative result cache with recency ranks and LRU or random eviction.
`timescale 1ns / 1ps
module rcc_cache #(
   parameter int MAX_ROD       = 255,
   parameter int CACHE_ENTRIES = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic [$clog2(MAX_ROD+1)-1:0] key,
   input  logic touch,
   input  logic insert,
   input  logic [23:0] insert_answer,
   input  logic policy,
   input  logic [3:0] capacity,
   output rcc_pkg::cache_status_type status
);
   localparam int RW = $clog2(MAX_ROD + 1);
   localparam int SW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int FW = $clog2(CACHE_ENTRIES + 1);

   typedef enum logic [1:0] {C_IDLE, C_MOD, C_DROP, C_PUT} state_type;

   state_type state_ff;
   logic [RW-1:0] key_mem [CACHE_ENTRIES];
   logic [23:0] ans_mem [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] valid_ff;
   logic [SW-1:0] rank_ff [CACHE_ENTRIES];
   logic [FW-1:0] fill_ff;
   logic [15:0] lfsr_ff, mod_src_ff;
   logic [3:0] bit_ff;
   logic [FW-1:0] rem_ff;
   logic [RW-1:0] ins_key_ff;
   logic [23:0] ins_ans_ff;

   logic hit;
   logic [SW-1:0] hit_slot;
   logic [23:0] hit_answer;
   logic [FW-1:0] cap;
   logic [15:0] lfsr_next;
   logic [FW:0] rem_shift;
   logic [FW-1:0] rem_next;
   logic vic_found;
   logic [SW-1:0] vic_slot;
   logic free_found;
   logic [SW-1:0] free_slot;

   always_comb begin
      hit = 1'b0;
      hit_slot = '0;
      hit_answer = '0;
      vic_found = 1'b0;
      vic_slot = '0;
      free_found = 1'b0;
      free_slot = '0;
      for (int j = CACHE_ENTRIES - 1; j >= 0; j--) begin
         if (valid_ff[j] && key_mem[j] == key) begin
            hit = 1'b1;
            hit_slot = SW'(j);
            hit_answer = ans_mem[j];
         end
         if (valid_ff[j] && 32'(rank_ff[j]) == 32'(rem_ff)) begin
            vic_found = 1'b1;
            vic_slot = SW'(j);
         end
         if (!valid_ff[j]) begin
            free_found = 1'b1;
            free_slot = SW'(j);
         end
      end
   end

   always_comb begin
      if (capacity == 4'd0) begin
         cap = FW'(1);
      end else if (32'(capacity) > CACHE_ENTRIES) begin
         cap = FW'(CACHE_ENTRIES);
      end else begin
         cap = FW'(capacity);
      end
   end

   assign lfsr_next = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? rcc_pkg::LFSR_TAPS : 16'd0);
   // Restoring remainder, one bit of the random word per cycle.
   assign rem_shift = {rem_ff, mod_src_ff[bit_ff]};
   assign rem_next  = (rem_shift >= {1'b0, fill_ff}) ? FW'(rem_shift - {1'b0, fill_ff})
                                                     : FW'(rem_shift);

   always_ff @(posedge clock) begin
      if (state_ff == C_IDLE && insert) begin
         ins_key_ff <= key;
         ins_ans_ff <= insert_answer;
      end
      if (state_ff == C_PUT && free_found) begin
         key_mem[free_slot] <= ins_key_ff;
         ans_mem[free_slot] <= ins_ans_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         valid_ff <= '0;
         for (int j = 0; j < CACHE_ENTRIES; j++) begin
            rank_ff[j] <= '0;
         end
         fill_ff <= '0;
         lfsr_ff <= rcc_pkg::LFSR_SEED;
      end else begin
         case (state_ff)
            C_IDLE: begin
               if (touch && hit) begin
                  for (int j = 0; j < CACHE_ENTRIES; j++) begin
                     if (SW'(j) != hit_slot && valid_ff[j] &&
                         rank_ff[j] > rank_ff[hit_slot]) begin
                        rank_ff[j] <= rank_ff[j] - SW'(1);
                     end
                  end
                  rank_ff[hit_slot] <= SW'(fill_ff - FW'(1));
               end else if (insert) begin
                  if (fill_ff >= cap && fill_ff != '0) begin
                     rem_ff <= '0;
                     if (policy == rcc_pkg::POLICY_RANDOM) begin
                        lfsr_ff    <= lfsr_next;
                        mod_src_ff <= lfsr_next;
                        bit_ff     <= 4'd15;
                        state_ff   <= C_MOD;
                     end else begin
                        state_ff <= C_DROP;
                     end
                  end else begin
                     state_ff <= C_PUT;
                  end
               end
            end
            C_MOD: begin
               rem_ff <= rem_next;
               bit_ff <= bit_ff - 4'd1;
               if (bit_ff == 4'd0) begin
                  state_ff <= C_DROP;
               end
            end
            C_DROP: begin
               if (vic_found) begin
                  valid_ff[vic_slot] <= 1'b0;
                  for (int j = 0; j < CACHE_ENTRIES; j++) begin
                     if (valid_ff[j] && 32'(rank_ff[j]) > 32'(rem_ff)) begin
                        rank_ff[j] <= rank_ff[j] - SW'(1);
                     end
                  end
                  fill_ff <= fill_ff - FW'(1);
               end
               state_ff <= C_PUT;
            end
            C_PUT: begin
               if (free_found) begin
                  valid_ff[free_slot] <= 1'b1;
                  rank_ff[free_slot]  <= SW'(fill_ff);
                  fill_ff <= fill_ff + FW'(1);
               end
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign status.hit      = hit;
   assign status.busy     = (state_ff != C_IDLE);
   assign status.overfull = (32'(fill_ff) > CACHE_ENTRIES);
   assign status.answer   = hit_answer;

endmodule

@@ design/rod_cutting_with_result_cache.sv @@
// Top level: request control, configuration registers, cache and solver.
// Usage:
// A request on req_data (valid/stall) either loads one piece table entry
// (kind 0, no response) or queries a rod length (kind 1, one response).
// Responses leave on rsp_data with rsp_valid/rsp_stall through an output
// register, so the next request is taken while a response still waits.
// Requests are handled one at a time; req_stall is high while one is busy.
// A load is written at acceptance. A cache hit answers from the lookup state
// once the output register is free. A miss runs the recurrence for each rod
// length in turn over the enabled pieces, through the single read port of
// the best-value memory; the next request waits for the cache insertion,
// in which a random victim needs a bit-serial remainder of the random word.
// The csr_ port writes replace_policy, piece_count and cache_capacity;
// write only while no request is in flight.
// Reset (synchronous) empties the cache, reseeds the random generator and
// restores the registers; piece and cache data memories are not cleared.
// A stalled response holds; the block does not finish a further query
// until the output register frees.
`timescale 1ns / 1ps
module rod_cutting_with_result_cache #(
   parameter int MAX_PIECES    = 16,
   parameter int MAX_ROD       = 255,
   parameter int CACHE_ENTRIES = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rcc_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rcc_pkg::rsp_type rsp_data,
   input  logic csr_write,
   input  logic [rcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int RW = $clog2(MAX_ROD + 1);
   localparam int CW = $clog2(MAX_PIECES + 1);

   typedef enum logic [2:0] {S_IDLE, S_LOOKUP, S_SOLVE, S_FINISH, S_SETTLE} state_type;

   state_type state_ff;
   logic policy_ff;
   logic [4:0] piece_count_ff;
   logic [3:0] capacity_ff;
   logic [RW-1:0] len_ff;
   logic [23:0] answer_ff;
   logic rsp_valid_ff;
   rcc_pkg::rsp_type rsp_data_ff;

   logic req_take, rsp_free, load_en, eng_start, eng_done, eng_busy;
   logic touch, insert, rsp_load;
   logic [RW-1:0] len_in;
   logic [CW-1:0] count;
   logic [23:0] eng_result;
   rcc_pkg::cache_status_type cstat;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign load_en = req_take && (req_data.kind == rcc_pkg::KIND_LOAD);

   assign len_in = (32'(req_data.rod_length) > MAX_ROD) ? RW'(MAX_ROD)
                                                        : RW'(req_data.rod_length);
   assign count = (32'(piece_count_ff) > MAX_PIECES) ? CW'(MAX_PIECES)
                                                     : CW'(piece_count_ff);

   assign eng_start = (state_ff == S_LOOKUP) && !cstat.hit;
   assign touch  = (state_ff == S_LOOKUP) && cstat.hit && rsp_free &&
                   (policy_ff == rcc_pkg::POLICY_LRU);
   assign insert = (state_ff == S_FINISH) && rsp_free;
   assign rsp_load = ((state_ff == S_LOOKUP) && cstat.hit && rsp_free) ||
                     ((state_ff == S_FINISH) && rsp_free);

   rcc_dp_engine #(.MAX_PIECES(MAX_PIECES), .MAX_ROD(MAX_ROD)) u_engine (
      .clock(clock), .reset(reset),
      .load_en(load_en), .load_index(req_data.piece_index),
      .load_length(req_data.piece_length), .load_value(req_data.piece_value),
      .start(eng_start), .rod_len(len_ff), .count(count),
      .done(eng_done), .result(eng_result), .busy(eng_busy)
   );

   rcc_cache #(.MAX_ROD(MAX_ROD), .CACHE_ENTRIES(CACHE_ENTRIES)) u_cache (
      .clock(clock), .reset(reset),
      .key(len_ff), .touch(touch), .insert(insert), .insert_answer(answer_ff),
      .policy(policy_ff), .capacity(capacity_ff), .status(cstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff      <= rcc_pkg::POLICY_LRU;
         piece_count_ff <= 5'd0;
         capacity_ff    <= 4'd5;
      end else if (csr_write) begin
         case (csr_index)
            rcc_pkg::CSR_REPLACE_POLICY: policy_ff <= csr_wdata[0];
            rcc_pkg::CSR_PIECE_COUNT:    piece_count_ff <= csr_wdata[4:0];
            rcc_pkg::CSR_CACHE_CAPACITY: capacity_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take && req_data.kind == rcc_pkg::KIND_QUERY) begin
                  len_ff   <= len_in;
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               if (!cstat.hit) begin
                  state_ff <= S_SOLVE;
               end else if (rsp_free) begin
                  rsp_data_ff.best_value <= cstat.answer;
                  rsp_data_ff.cache_hit  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_SOLVE: begin
               if (eng_done) begin
                  answer_ff <= eng_result;
                  state_ff  <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (rsp_free) begin
                  rsp_data_ff.best_value <= answer_ff;
                  rsp_data_ff.cache_hit  <= 1'b0;
                  state_ff <= S_SETTLE;
               end
            end
            S_SETTLE: begin
               if (!cstat.busy) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_engine_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !eng_busy)
      else $error("solver busy while controller is idle");
   a_cache_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_LOOKUP || state_ff == S_SOLVE) |-> !cstat.busy)
      else $error("cache update overlaps a lookup");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      !cstat.overfull)
      else $error("cache fill exceeds entry count");
   a_done_in_solve: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> (state_ff == S_SOLVE))
      else $error("solver result outside solve phase");
`endif

endmodule

@@ tb/rod_cutting_with_result_cache_tb.sv @@
// Self-checking testbench for the rod cutting block with its result cache.
`timescale 1ns / 1ps
module rod_cutting_with_result_cache_tb;

   localparam int STUCK_LIMIT  = 20000;
   localparam int SETTLE_TICKS = 40;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   rcc_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rcc_pkg::rsp_type rsp_data;
   logic csr_write;
   logic [rcc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rcc_pkg::CSR_DATA_W-1:0] csr_wdata;

   rod_cutting_with_result_cache dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predicted block state.
   rcc_pkg::policy_type policy_reg;
   logic [4:0]  count_reg;
   logic [3:0]  capacity_reg;
   logic [7:0]  piece_len_mem [16];
   logic [15:0] piece_val_mem [16];
   bit          slot_used [8];
   logic [7:0]  slot_key [8];
   logic [23:0] slot_answer [8];
   int          slot_order [8];
   int          slots_filled;
   logic [15:0] victim_lfsr;

   rcc_pkg::rsp_type answers_due [$];
   rcc_pkg::req_type outgoing [$];
   int      requests_taken;
   int      requests_issued;
   int      gap_left;
   int      stall_left;
   int      hold_left;
   bit      idle_on;
   int      errors;
   int      hits_seen;
   int      misses_seen;
   int      stuck_ticks;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [23:0] best_cut_value(logic [7:0] len);
      int best [256];
      int count;
      int cand;
      int b;
      count = (count_reg > 16) ? 16 : int'(count_reg);
      best[0] = 0;
      for (int i = 1; i <= len; i++) begin
         b = 0;
         for (int j = 0; j < count; j++) begin
            if (piece_len_mem[j] != 0 && piece_len_mem[j] <= i) begin
               cand = piece_val_mem[j] + best[i - piece_len_mem[j]];
               if (cand > rcc_pkg::VALUE_MAX) cand = rcc_pkg::VALUE_MAX;
               if (cand > b) b = cand;
            end
         end
         best[i] = b;
      end
      return 24'(best[len]);
   endfunction

   function automatic void drop_slot(int s);
      slot_used[s] = 0;
      for (int j = 0; j < 8; j++)
         if (slot_used[j] && slot_order[j] > slot_order[s]) slot_order[j]--;
      if (slots_filled > 0) slots_filled--;
   endfunction

   function automatic void cache_insert(logic [7:0] key, logic [23:0] answer);
      int cap;
      int victim;
      cap = (capacity_reg == 0) ? 1 : (capacity_reg > 8 ? 8 : int'(capacity_reg));
      if (slots_filled >= cap && slots_filled > 0) begin
         victim = 0;
         if (policy_reg == rcc_pkg::POLICY_RANDOM) begin
            victim_lfsr = (victim_lfsr >> 1) ^
                          (victim_lfsr[0] ? rcc_pkg::LFSR_TAPS : 16'h0);
            victim = victim_lfsr % slots_filled;
         end
         for (int j = 0; j < 8; j++)
            if (slot_used[j] && slot_order[j] == victim) begin
               drop_slot(j);
               break;
            end
      end
      for (int j = 0; j < 8; j++)
         if (!slot_used[j]) begin
            slot_used[j] = 1;
            slot_key[j] = key;
            slot_answer[j] = answer;
            slot_order[j] = slots_filled;
            slots_filled++;
            break;
         end
   endfunction

   function automatic void predict_request(rcc_pkg::req_type r);
      rcc_pkg::rsp_type e;
      bit hit;
      if (r.kind == rcc_pkg::KIND_LOAD) begin
         piece_len_mem[r.piece_index] = r.piece_length;
         piece_val_mem[r.piece_index] = r.piece_value;
         return;
      end
      hit = 0;
      for (int j = 0; j < 8; j++)
         if (!hit && slot_used[j] && slot_key[j] == r.rod_length) begin
            hit = 1;
            e.best_value = slot_answer[j];
            if (policy_reg == rcc_pkg::POLICY_LRU) begin
               for (int k = 0; k < 8; k++)
                  if (k != j && slot_used[k] && slot_order[k] > slot_order[j])
                     slot_order[k]--;
               slot_order[j] = slots_filled - 1;
            end
         end
      if (!hit) begin
         e.best_value = best_cut_value(r.rod_length);
         cache_insert(r.rod_length, e.best_value);
      end
      e.cache_hit = hit;
      answers_due.push_back(e);
   endfunction

   // Request driver: one assignment per edge, prediction at acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_request(req_data);
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (outgoing.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= outgoing.pop_front();
               if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response receiver: random stall bursts plus an optional long hold-off.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rcc_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response best_value=%0d hit=%0b", $time,
                     rsp_data.best_value, rsp_data.cache_hit);
            errors++;
         end else begin
            e = answers_due.pop_front();
            if (rsp_data.best_value !== e.best_value) begin
               $display("%0t: best_value expected %0d actual %0d", $time,
                        e.best_value, rsp_data.best_value);
               errors++;
            end
            if (rsp_data.cache_hit !== e.cache_hit) begin
               $display("%0t: cache_hit expected %0b actual %0b", $time,
                        e.cache_hit, rsp_data.cache_hit);
               errors++;
            end
            if (e.cache_hit) hits_seen++;
            else misses_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (answers_due.size() == 0 && outgoing.size() == 0 && !req_valid)) begin
         stuck_ticks = 0;
      end else begin
         stuck_ticks++;
         if (stuck_ticks >= STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("rod_cutting_with_result_cache_tb: errors");
            $finish;
         end
      end
   end

   task automatic send_request(rcc_pkg::req_type r);
      int ticket;
      ticket = requests_issued++;
      outgoing.push_back(r);
      wait (requests_taken > ticket);
   endtask

   task automatic load_piece(int slot, int len, int val);
      rcc_pkg::req_type r;
      r = '0;
      r.kind = rcc_pkg::KIND_LOAD;
      r.piece_index = 4'(slot);
      r.piece_length = 8'(len);
      r.piece_value = 16'(val);
      r.rod_length = 8'($urandom);
      send_request(r);
   endtask

   task automatic ask_rod(int len);
      rcc_pkg::req_type r;
      r = '0;
      r.piece_index = 4'($urandom);
      r.piece_length = 8'($urandom);
      r.piece_value = 16'($urandom);
      r.kind = rcc_pkg::KIND_QUERY;
      r.rod_length = 8'(len);
      send_request(r);
   endtask

   task automatic wait_quiet();
      wait (outgoing.size() == 0 && answers_due.size() == 0);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_put(rcc_pkg::csr_index_type idx, int val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 5'(val);
      @(posedge clock);
   endtask

   task automatic configure(rcc_pkg::policy_type pol, int count, int cap);
      wait_quiet();
      csr_put(rcc_pkg::CSR_REPLACE_POLICY, pol);
      csr_put(rcc_pkg::CSR_PIECE_COUNT, count);
      csr_put(rcc_pkg::CSR_CACHE_CAPACITY, cap);
      csr_write <= 1'b0;
      policy_reg = pol;
      count_reg = 5'(count);
      capacity_reg = 4'(cap);
   endtask

   // With no pieces enabled every length is worth zero.
   task automatic test_empty_table();
      ask_rod(0);
      ask_rod(255);
      ask_rod(0);
   endtask

   task automatic test_load_table();
      load_piece(0, 1, 16'hFFFF);
      load_piece(1, 255, 0);
      load_piece(2, 0, 16'hFFFF);
      for (int s = 3; s < 16; s++) load_piece(s, $urandom_range(1, 40), $urandom);
      load_piece(15, 8'hAA, 16'h5555);
   endtask

   task automatic test_directed();
      configure(rcc_pkg::POLICY_LRU, 16, 8);
      ask_rod(255);
      ask_rod(1);
      ask_rod(0);
      ask_rod(255);
      // An oversize count clamps to the table size; capacity 0 acts as one.
      configure(rcc_pkg::POLICY_LRU, 31, 0);
      ask_rod(3);
      ask_rod(1);
      ask_rod(3);
      configure(rcc_pkg::POLICY_LRU, 5, 15);
      for (int i = 4; i < 13; i++) ask_rod(i);
      ask_rod(5);
      // Capacity dropped below the fill count evicts only one entry per insert.
      configure(rcc_pkg::POLICY_LRU, 5, 2);
      ask_rod(20);
      ask_rod(6);
   endtask

   task automatic test_random_policy();
      configure(rcc_pkg::POLICY_RANDOM, 16, 3);
      for (int i = 0; i < 12; i++) ask_rod($urandom_range(0, 6));
   endtask

   task automatic test_backpressure();
      configure(rcc_pkg::POLICY_LRU, 4, 4);
      hold_left = 300;
      for (int i = 0; i < 10; i++) ask_rod($urandom_range(0, 12));
      wait_quiet();
   endtask

   task automatic test_random_mix(int total);
      int kind_roll;
      for (int n = 0; n < total; n++) begin
         if (n % 20 == 19)
            configure(rcc_pkg::policy_type'($urandom_range(0, 1)), $urandom_range(0, 31),
                      $urandom_range(0, 15));
         if (n == total - 30) idle_on = 0;
         kind_roll = $urandom_range(0, 9);
         if (kind_roll < 2) load_piece($urandom_range(0, 15), $urandom_range(0, 255), $urandom);
         else if (kind_roll == 2) ask_rod($urandom_range(0, 255));
         else ask_rod($urandom_range(0, 14));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      policy_reg = rcc_pkg::POLICY_LRU;
      count_reg = 5'd0;
      capacity_reg = 4'd5;
      slots_filled = 0;
      victim_lfsr = rcc_pkg::LFSR_SEED;
      foreach (slot_used[j]) begin
         slot_used[j] = 0;
         slot_order[j] = 0;
      end
      requests_taken = 0;
      requests_issued = 0;
      gap_left = 0;
      stall_left = 0;
      hold_left = 0;
      idle_on = 1;
      errors = 0;
      hits_seen = 0;
      misses_seen = 0;
      stuck_ticks = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_load_table();
      test_directed();
      test_random_policy();
      test_backpressure();
      test_random_mix(80);
      wait_quiet();

      $display("Covered %0d requests: %0d cache hits and %0d misses,", requests_taken,
               hits_seen, misses_seen);
      $display("under both replacement policies, clamped registers and backpressure.");
      if (errors == 0 && answers_due.size() == 0) begin
         $display("rod_cutting_with_result_cache_tb: clean");
      end else begin
         $display("rod_cutting_with_result_cache_tb: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/rcc_pkg.sv
design/rcc_dp_engine.sv
design/rcc_cache.sv
design/rod_cutting_with_result_cache.sv
tb/rod_cutting_with_result_cache_tb.sv
